// ===== sv/mpq_pkg.sv =====
`timescale 1ns / 1ps
// mpq_pkg: shared types and constants for the min-first priority queue.
// No dependencies; used by mpq_cell and min_priority_queue.
package mpq_pkg;

    localparam int unsigned MPQ_CAPACITY = 16;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned PRIO_W       = 8;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned OCC_W        = 5;

    // command codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // one queue slot as seen by its neighbors
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
        logic        [PRIO_W-1:0] prio;
    } t_entry;

    // per-transaction operation broadcast to every cell
    typedef struct packed {
        logic enq;  // insert (queue known not full)
        logic deq;  // remove head (queue known not empty)
    } t_cell_ctl;

endpackage

// ===== sv/mpq_cell.sv =====
`timescale 1ns / 1ps
// mpq_cell: one slot of the sorted chain; shifts right on insert, left on remove.
// Depends on mpq_pkg.
module mpq_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mpq_pkg::t_cell_ctl               i_ctl,
    input  logic signed [mpq_pkg::DATA_W-1:0] i_new_data,
    input  logic        [mpq_pkg::PRIO_W-1:0] i_new_prio,
    input  mpq_pkg::t_entry                  i_left,
    input  logic                             i_left_ins,
    input  mpq_pkg::t_entry                  i_right,
    output mpq_pkg::t_entry                  o_entry,
    output logic                             o_ins
);
    import mpq_pkg::*;

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_data;
    logic        [PRIO_W-1:0] r_prio;

    // new item belongs at or before this slot: empty, or strictly larger priority
    assign o_ins = !r_valid || (r_prio > i_new_prio);

    assign o_entry = '{valid: r_valid, data: r_data, prio: r_prio};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.enq && o_ins) begin
            r_valid <= i_left_ins ? i_left.valid : 1'b1;
        end else if (i_ctl.deq) begin
            r_valid <= i_right.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.enq && o_ins) begin
            if (i_left_ins) begin
                r_data <= i_left.data;
                r_prio <= i_left.prio;
            end else begin
                r_data <= i_new_data;
                r_prio <= i_new_prio;
            end
        end else if (i_ctl.deq) begin
            r_data <= i_right.data;
            r_prio <= i_right.prio;
        end
    end

endmodule

// ===== sv/min_priority_queue.sv =====
`timescale 1ns / 1ps
// min_priority_queue: top level, a sorted chain of mpq_cell slots plus count and result register.
// Depends on mpq_pkg and mpq_cell.
//
// Bounded priority queue, lowest priority value served first, ties in arrival order.
// The entries sit in a chain of CAPACITY cells kept sorted at all times: an enqueue
// compares its priority against every cell at once and each cell either holds, takes
// its left neighbor, or takes the new word; a dequeue shifts every cell one step
// toward the head. Either operation completes in the clock cycle its transaction is
// accepted, so the block takes one transaction per cycle while its input is not stalled,
// and the result is written into the output register on acceptance. The one compare per
// cell plus the head-of-queue read set the cycle time. Input is stalled only while
// a finished result sits in the output register and the consumer stalls it.
// Every transaction yields exactly one result: data_out (the removed word, else
// zero), status (ok, empty on dequeue, full on enqueue) and occupancy after the
// transaction, reported modulo 32. Storage has no reset beyond the per-cell valid
// flags and the entry count; no clearing pass is needed.
module min_priority_queue #(
    parameter int unsigned CAPACITY = mpq_pkg::MPQ_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_command,
    input  logic signed [mpq_pkg::DATA_W-1:0]   i_data_in,
    input  logic        [mpq_pkg::PRIO_W-1:0]   i_priority_in,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [mpq_pkg::DATA_W-1:0]   o_data_out,
    output logic        [mpq_pkg::STATUS_W-1:0] o_status,
    output logic        [mpq_pkg::OCC_W-1:0]    o_occupancy
);
    import mpq_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic                     in_accept;
    logic                     q_full;
    logic                     q_empty;
    t_cell_ctl                ctl;

    t_entry                   cell_q    [CAPACITY];
    logic   [CAPACITY-1:0]    cell_ins;
    logic   [CAPACITY-1:0]    cell_valid;
    t_entry                   left_in   [CAPACITY];
    logic   [CAPACITY-1:0]    left_ins;
    t_entry                   right_in  [CAPACITY];

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [CNT_W+OCC_W-1:0]   occ_ext;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_data_out;
    logic [STATUS_W-1:0]      r_status;
    logic [OCC_W-1:0]         r_occupancy;
    logic signed [DATA_W-1:0] n_data_out;
    logic [STATUS_W-1:0]      n_status;

    // output register frees when empty or being taken
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign q_full  = (r_count == CNT_W'(CAPACITY));
    assign q_empty = (r_count == '0);

    assign ctl.enq = in_accept && (i_command == CMD_ENQ) && !q_full;
    assign ctl.deq = in_accept && (i_command == CMD_DEQ) && !q_empty;

    // neighbor wiring; head sees a valid "stop" to its left, tail an empty slot to its right
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_valid[i] = cell_q[i].valid;
            if (i == 0) begin
                left_in[i]  = '{valid: 1'b1, data: '0, prio: '0};
                left_ins[i] = 1'b0;
            end else begin
                left_in[i]  = cell_q[i-1];
                left_ins[i] = cell_ins[i-1];
            end
            if (i == CAPACITY - 1) begin
                right_in[i] = '{valid: 1'b0, data: '0, prio: '0};
            end else begin
                right_in[i] = cell_q[i+1];
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        mpq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_new_data (i_data_in),
            .i_new_prio (i_priority_in),
            .i_left     (left_in[g]),
            .i_left_ins (left_ins[g]),
            .i_right    (right_in[g]),
            .o_entry    (cell_q[g]),
            .o_ins      (cell_ins[g])
        );
    end

    // result of the transaction being accepted
    always_comb begin
        n_count    = r_count;
        n_data_out = '0;
        n_status   = ST_OK;
        if (i_command == CMD_ENQ) begin
            if (q_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (q_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_data_out = cell_q[0].data;
                n_count    = r_count - CNT_W'(1);
            end
        end
    end

    assign occ_ext = (CNT_W + OCC_W)'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_data_out  <= n_data_out;
            r_status    <= n_status;
            r_occupancy <= occ_ext[OCC_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_status    = r_status;
    assign o_occupancy = r_occupancy;

    // count tracks the number of occupied cells
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(cell_valid) == int'(r_count))
        else $error("entry count disagrees with occupied cells");

    // occupied cells form a contiguous run from the head
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, cell_valid} + (CAPACITY + 1)'(1)))
        else $error("occupied cells not contiguous from head");

    // head never has a larger priority than its successor
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_q[1].valid |-> (cell_q[0].prio <= cell_q[1].prio))
        else $error("head out of priority order");

    // a dequeue on a non-empty queue reports ok
    a_deq_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_command == CMD_DEQ) && !q_empty) |=> (r_status == ST_OK))
        else $error("dequeue on non-empty queue did not report ok");

endmodule

// ===== bench/min_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// min_priority_queue_tb: self-checking bench for the min-first priority queue.
// Depends on mpq_pkg and min_priority_queue; runs a directed table, then random traffic.
module min_priority_queue_tb;
    import mpq_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_ITEMS = 50;

    // one result of the block as the checker sees it
    typedef struct packed {
        logic signed [DATA_W-1:0]   data;
        logic        [STATUS_W-1:0] status;
        logic        [OCC_W-1:0]    occ;
    } t_txn_result;

    // one held entry of the predicted queue
    typedef struct {
        logic signed [DATA_W-1:0] data;
        logic        [PRIO_W-1:0] prio;
    } t_held;

    // directed stimulus row; 'typed' rows carry their expected result inline
    typedef struct {
        logic                     cmd;
        logic signed [DATA_W-1:0] data;
        logic        [PRIO_W-1:0] prio;
        bit                       typed;
        t_txn_result              want;
    } t_stim_row;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_in_valid    = 1'b0;
    logic                      o_in_stall;
    logic                      i_command     = CMD_ENQ;
    logic signed [DATA_W-1:0]  i_data_in     = '0;
    logic        [PRIO_W-1:0]  i_priority_in = '0;
    logic                      o_out_valid;
    logic                      i_out_stall   = 1'b0;
    logic signed [DATA_W-1:0]  o_data_out;
    logic        [STATUS_W-1:0] o_status;
    logic        [OCC_W-1:0]   o_occupancy;

    t_held       held_queue[$];        // predicted contents, in service order
    t_txn_result awaited_results[$];   // results still owed by the block
    int          fail_count    = 0;
    int          results_seen  = 0;
    int unsigned cycle_count   = 0;

    // Full queue reached by row 16; row 17 must bounce with status full.
    t_stim_row directed_rows [0:23] = '{
        '{CMD_DEQ, 32'sd0,          8'd0,   1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
        '{CMD_ENQ, 32'sh7FFF_FFFF,  8'd255, 1'b1, '{32'sd0, ST_OK,    5'd1}},
        '{CMD_ENQ, 32'sh8000_0000,  8'd0,   1'b1, '{32'sd0, ST_OK,    5'd2}},
        '{CMD_ENQ, 32'shFFFF_FFFF,  8'd128, 1'b1, '{32'sd0, ST_OK,    5'd3}},
        '{CMD_ENQ, 32'sh0000_0000,  8'd128, 1'b1, '{32'sd0, ST_OK,    5'd4}},
        '{CMD_ENQ, 32'sh5555_5555,  8'd1,   1'b1, '{32'sd0, ST_OK,    5'd5}},
        '{CMD_ENQ, 32'shAAAA_AAAA,  8'd254, 1'b1, '{32'sd0, ST_OK,    5'd6}},
        '{CMD_ENQ, 32'sh0000_0001,  8'd0,   1'b1, '{32'sd0, ST_OK,    5'd7}},
        '{CMD_ENQ, 32'sh7FFF_FFFE,  8'd255, 1'b1, '{32'sd0, ST_OK,    5'd8}},
        '{CMD_ENQ, 32'sh0000_0040,  8'd64,  1'b1, '{32'sd0, ST_OK,    5'd9}},
        '{CMD_ENQ, 32'sh0000_0041,  8'd64,  1'b1, '{32'sd0, ST_OK,    5'd10}},
        '{CMD_ENQ, 32'sh0000_0042,  8'd64,  1'b1, '{32'sd0, ST_OK,    5'd11}},
        '{CMD_ENQ, 32'sh0000_C8C8,  8'd200, 1'b1, '{32'sd0, ST_OK,    5'd12}},
        '{CMD_ENQ, 32'shFFFF_0003,  8'd3,   1'b1, '{32'sd0, ST_OK,    5'd13}},
        '{CMD_ENQ, 32'sh1234_5678,  8'd128, 1'b1, '{32'sd0, ST_OK,    5'd14}},
        '{CMD_ENQ, 32'sh0000_0011,  8'd17,  1'b1, '{32'sd0, ST_OK,    5'd15}},
        '{CMD_ENQ, 32'sh0000_0064,  8'd100, 1'b1, '{32'sd0, ST_OK,    5'd16}},
        '{CMD_ENQ, 32'sh0F0F_0F0F,  8'd0,   1'b1, '{32'sd0, ST_FULL,  5'd16}},
        '{CMD_DEQ, 32'sd0,          8'd0,   1'b0, '{32'sd0, ST_OK,    5'd0}},
        '{CMD_DEQ, 32'sd0,          8'd0,   1'b0, '{32'sd0, ST_OK,    5'd0}},
        '{CMD_DEQ, 32'sd0,          8'd0,   1'b0, '{32'sd0, ST_OK,    5'd0}},
        '{CMD_DEQ, 32'sd0,          8'd0,   1'b0, '{32'sd0, ST_OK,    5'd0}},
        '{CMD_ENQ, 32'shF0F0_F0F0,  8'd0,   1'b0, '{32'sd0, ST_OK,    5'd0}},
        '{CMD_DEQ, 32'sd0,          8'd0,   1'b0, '{32'sd0, ST_OK,    5'd0}}
    };

    min_priority_queue u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_data_in     (i_data_in),
        .i_priority_in (i_priority_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_data_out    (o_data_out),
        .o_status      (o_status),
        .o_occupancy   (o_occupancy)
    );

    always #4 i_clk = ~i_clk;

    // Applies one transaction to the predicted queue and returns what the block should report.
    // New entries go behind every entry of equal or lower priority, so ties stay in arrival order.
    function automatic t_txn_result predict_queue_result(input logic cmd,
                                                         input logic signed [DATA_W-1:0] data,
                                                         input logic [PRIO_W-1:0] prio);
        t_txn_result res;
        t_held       entry;
        int          pos;
        res = '{data: '0, status: ST_OK, occ: '0};
        if (cmd == CMD_ENQ) begin
            if (held_queue.size() >= MPQ_CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                pos = held_queue.size();
                while (pos > 0 && held_queue[pos-1].prio > prio) pos--;
                entry.data = data;
                entry.prio = prio;
                held_queue.insert(pos, entry);
            end
        end else begin
            if (held_queue.size() == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.data = held_queue[0].data;
                held_queue.delete(0);
            end
        end
        res.occ = OCC_W'(held_queue.size());
        return res;
    endfunction

    // Idle length: style 0 never idles; otherwise mostly zero or short, now and then long.
    function automatic int pick_gap(input int style);
        int roll;
        if (style == 0) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one transaction, holds it until accepted, records the expected result, then idles.
    // Called at a rising edge; valid stays high across back-to-back transactions.
    task automatic send_transaction(input logic cmd, input logic signed [DATA_W-1:0] data,
                                    input logic [PRIO_W-1:0] prio, input bit typed,
                                    input t_txn_result want, input int gap_style);
        t_txn_result predicted;
        int          gap;
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_data_in     <= data;
        i_priority_in <= prio;
        do @(posedge i_clk); while (o_in_stall);
        predicted = predict_queue_result(cmd, data, prio);
        awaited_results.push_back(typed ? want : predicted);
        gap = pick_gap(gap_style);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Result side: checks each accepted result and drives the stall pattern.
    // After 60 results the consumer goes quiet for a long stretch so the block backs up.
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    int  stall_left = 0;
    int  rx_style   = 1;
    int  style_left = 0;
    always @(posedge i_clk) begin
        t_txn_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: data_out %0d status %0d occupancy %0d",
                           o_data_out, o_status, o_occupancy);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (o_data_out !== want.data) begin
                        $error("data_out: expected %0d, got %0d", want.data, o_data_out);
                        fail_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_occupancy !== want.occ) begin
                        $error("occupancy: expected %0d, got %0d", want.occ, o_occupancy);
                        fail_count++;
                    end
                end
            end
            if (!hold_done && results_seen == 60) begin
                hold_left = 250;
                hold_done = 1'b1;
            end
            if (style_left == 0) begin
                rx_style   = $urandom_range(0, 2);
                style_left = $urandom_range(20, 80);
            end else begin
                style_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                stall_left = pick_gap(rx_style);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int                       phase;
        int                       item;
        int                       enq_pct;
        int                       prio_mode;
        int                       tx_style;
        int                       roll;
        logic                     cmd;
        logic signed [DATA_W-1:0] data;
        logic        [PRIO_W-1:0] prio;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_transaction(directed_rows[r].cmd, directed_rows[r].data, directed_rows[r].prio,
                             directed_rows[r].typed, directed_rows[r].want, 1);
        end

        // Random phases alternate fill-heavy, drain-heavy and balanced traffic so that
        // the full and empty cases keep coming back with fresh contents.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase % 3)
                0:       enq_pct = 85;
                1:       enq_pct = 20;
                default: enq_pct = 50;
            endcase
            prio_mode = $urandom_range(0, 1);   // narrow range forces many ties
            tx_style  = $urandom_range(0, 2);
            for (item = 0; item < PHASE_ITEMS; item++) begin
                cmd  = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
                data = $urandom;
                prio = (prio_mode == 0) ? PRIO_W'($urandom_range(0, 3))
                                        : PRIO_W'($urandom_range(0, 255));
                roll = $urandom_range(0, 9);
                if (roll == 0) prio = '0;
                else if (roll == 1) prio = '1;
                send_transaction(cmd, data, prio, 1'b0, '0, tx_style);
            end
        end
        i_in_valid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
